// ===== rtl/pmis_pkg.sv =====
// ----------------------------------------------------------------------------
// pmis_pkg
// Types and constants shared by the PHY management-bus init sequencer.
// ----------------------------------------------------------------------------
package pmis_pkg;

  // Input command codes.
  localparam logic [1:0] OP_START_INIT = 2'd0;
  localparam logic [1:0] OP_RESTART_AN = 2'd1;
  localparam logic [1:0] OP_REFRESH    = 2'd2;
  localparam logic [1:0] OP_READ_RESP  = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_RESET_TO   = 2'd1;
  localparam logic [1:0] ERR_AUTONEG_TO = 2'd2;

  // Speed codes.
  localparam logic [1:0] SPEED_10M   = 2'd0;
  localparam logic [1:0] SPEED_100M  = 2'd1;
  localparam logic [1:0] SPEED_1000M = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RESET_POLL_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_AUTONEG_POLL_LIMIT = 2'd1;
  localparam logic [1:0] CFG_ADVERTISE_GIG      = 2'd2;
  localparam logic [1:0] CFG_ADVERTISE_BASE     = 2'd3;

  // PHY register numbers.
  localparam logic [4:0] REG_CONTROL   = 5'd0;
  localparam logic [4:0] REG_STATUS    = 5'd1;
  localparam logic [4:0] REG_ADV_BASE  = 5'd4;
  localparam logic [4:0] REG_ADV_GIG   = 5'd9;
  localparam logic [4:0] REG_PHY_STAT  = 5'h1A;

  // Register bit patterns.
  localparam logic [15:0] ID_PATTERN    = 16'h1808;
  localparam logic [15:0] NO_DEVICE     = 16'hFFFF;
  localparam logic [15:0] CTRL_RESET    = 16'h8000;
  localparam logic [15:0] CTRL_AN_EN    = 16'h1000;
  localparam logic [15:0] CTRL_AN_RST   = 16'h0200;
  localparam logic [15:0] STAT_AN_DONE  = 16'h0020;

  // Reset values of the configuration registers.
  localparam logic [15:0] RST_RESET_POLL_LIMIT   = 16'd10000;
  localparam logic [15:0] RST_AUTONEG_POLL_LIMIT = 16'd50000;
  localparam logic [15:0] RST_ADVERTISE_GIG      = 16'h0300;
  localparam logic [15:0] RST_ADVERTISE_BASE     = 16'h01E0;

  // Sequencer phases, one-hot.
  typedef enum logic [8:0] {
    PH_IDLE     = 9'b0_0000_0001,
    PH_SCAN     = 9'b0_0000_0010,
    PH_RST_RD   = 9'b0_0000_0100,
    PH_RST_POLL = 9'b0_0000_1000,
    PH_GIG_RD   = 9'b0_0001_0000,
    PH_BASE_RD  = 9'b0_0010_0000,
    PH_CTRL_RD  = 9'b0_0100_0000,
    PH_AN_POLL  = 9'b0_1000_0000,
    PH_STAT_RD  = 9'b1_0000_0000
  } phase_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] read_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  phy_address;
    logic [4:0]  register_number;
    logic [15:0] write_data;
    logic [1:0]  speed_code;
    logic        full_duplex;
    logic        link_is_up;
    logic [1:0]  error_code;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] reset_poll_limit;
    logic [15:0] autoneg_poll_limit;
    logic [15:0] advertise_gig_bits;
    logic [15:0] advertise_base_bits;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [4:0]  found_address;
    logic [4:0]  scan_address;
    logic [15:0] poll_left;
    logic [1:0]  speed_held;
    logic        duplex_held;
    logic        link_held;
  } seq_state_t;

endpackage

// ===== rtl/pmis_step.sv =====
// ----------------------------------------------------------------------------
// pmis_step
// Next-state and result logic for one command or read response.
// ----------------------------------------------------------------------------
module pmis_step #(
  parameter logic [4:0] SCAN_START_ADDR = 5'd31
) (
  input  pmis_pkg::seq_state_t cur,
  input  pmis_pkg::cfg_t       cfg,
  input  pmis_pkg::in_item_t   item,
  output pmis_pkg::seq_state_t nxt,
  output pmis_pkg::out_item_t  res0,
  output pmis_pkg::out_item_t  res1,
  output logic [1:0]           res_count
);
  import pmis_pkg::*;

  function automatic out_item_t mk_read(input logic [4:0] addr, input logic [4:0] regn);
    out_item_t r;
    r = '0;
    r.kind = KIND_READ;
    r.phy_address = addr;
    r.register_number = regn;
    return r;
  endfunction

  function automatic out_item_t mk_write(input logic [4:0] addr, input logic [4:0] regn,
                                         input logic [15:0] val);
    out_item_t r;
    r = '0;
    r.kind = KIND_WRITE;
    r.phy_address = addr;
    r.register_number = regn;
    r.write_data = val;
    return r;
  endfunction

  function automatic out_item_t mk_error(input logic [4:0] addr, input logic [1:0] code);
    out_item_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.phy_address = addr;
    r.error_code = code;
    return r;
  endfunction

  logic [4:0]  addr;
  logic [15:0] d;
  logic        id_match;
  logic [1:0]  sc;
  out_item_t   r0;
  out_item_t   r1;
  logic [1:0]  n;

  assign addr = cur.found_address;
  assign d = item.read_data;
  assign id_match = (d != NO_DEVICE) && ((d & ID_PATTERN) == ID_PATTERN);
  assign sc = d[15:14];

  // Decode the item against the current phase.
  always_comb begin
    nxt = cur;
    r0 = '0;
    r1 = '0;
    n = 2'd0;
    case (item.opcode)
      OP_START_INIT: begin
        nxt.speed_held = SPEED_10M;
        nxt.duplex_held = 1'b0;
        nxt.link_held = 1'b0;
        nxt.scan_address = SCAN_START_ADDR;
        nxt.phase = PH_SCAN;
        r0 = mk_read(SCAN_START_ADDR, REG_STATUS);
        n = 2'd1;
      end
      OP_RESTART_AN: begin
        nxt.phase = PH_GIG_RD;
        r0 = mk_read(addr, REG_ADV_GIG);
        n = 2'd1;
      end
      OP_REFRESH: begin
        nxt.phase = PH_STAT_RD;
        r0 = mk_read(addr, REG_PHY_STAT);
        n = 2'd1;
      end
      default: begin
        // Read response: advance the running sequence.
        case (cur.phase)
          PH_SCAN: begin
            n = 2'd1;
            if (id_match) begin
              nxt.found_address = cur.scan_address;
              nxt.phase = PH_RST_RD;
              r0 = mk_read(cur.scan_address, REG_CONTROL);
            end else if (cur.scan_address > 5'd1) begin
              nxt.scan_address = cur.scan_address - 5'd1;
              r0 = mk_read(cur.scan_address - 5'd1, REG_STATUS);
            end else begin
              nxt.found_address = 5'd0;
              nxt.phase = PH_RST_RD;
              r0 = mk_read(5'd0, REG_CONTROL);
            end
          end
          PH_RST_RD: begin
            r0 = mk_write(addr, REG_CONTROL, d | CTRL_RESET);
            r1 = mk_read(addr, REG_CONTROL);
            nxt.poll_left = cfg.reset_poll_limit;
            nxt.phase = PH_RST_POLL;
            n = 2'd2;
          end
          PH_RST_POLL: begin
            n = 2'd1;
            if (cur.poll_left == 16'd0) begin
              r0 = mk_error(addr, ERR_RESET_TO);
              nxt.phase = PH_IDLE;
            end else begin
              nxt.poll_left = cur.poll_left - 16'd1;
              if ((d & CTRL_RESET) != 16'd0) begin
                r0 = mk_read(addr, REG_CONTROL);
              end else begin
                nxt.phase = PH_GIG_RD;
                r0 = mk_read(addr, REG_ADV_GIG);
              end
            end
          end
          PH_GIG_RD: begin
            r0 = mk_write(addr, REG_ADV_GIG, d | cfg.advertise_gig_bits);
            r1 = mk_read(addr, REG_ADV_BASE);
            nxt.phase = PH_BASE_RD;
            n = 2'd2;
          end
          PH_BASE_RD: begin
            r0 = mk_write(addr, REG_ADV_BASE, d | cfg.advertise_base_bits);
            r1 = mk_read(addr, REG_CONTROL);
            nxt.phase = PH_CTRL_RD;
            n = 2'd2;
          end
          PH_CTRL_RD: begin
            r0 = mk_write(addr, REG_CONTROL, d | CTRL_AN_EN | CTRL_AN_RST);
            r1 = mk_read(addr, REG_STATUS);
            nxt.poll_left = cfg.autoneg_poll_limit;
            nxt.phase = PH_AN_POLL;
            n = 2'd2;
          end
          PH_AN_POLL: begin
            n = 2'd1;
            if (cur.poll_left == 16'd0) begin
              r0 = mk_error(addr, ERR_AUTONEG_TO);
              nxt.phase = PH_IDLE;
            end else begin
              nxt.poll_left = cur.poll_left - 16'd1;
              if ((d & STAT_AN_DONE) != 16'd0) begin
                nxt.phase = PH_STAT_RD;
                r0 = mk_read(addr, REG_PHY_STAT);
              end else begin
                r0 = mk_read(addr, REG_STATUS);
              end
            end
          end
          PH_STAT_RD: begin
            // A speed code of 3 is taken as 10M.
            case (sc)
              2'd2:    nxt.speed_held = SPEED_1000M;
              2'd1:    nxt.speed_held = SPEED_100M;
              default: nxt.speed_held = SPEED_10M;
            endcase
            nxt.duplex_held = d[13];
            nxt.link_held = d[2];
            nxt.phase = PH_IDLE;
            r0 = '0;
            r0.kind = KIND_STATUS;
            r0.phy_address = addr;
            r0.speed_code = nxt.speed_held;
            r0.full_duplex = d[13];
            r0.link_is_up = d[2];
            n = 2'd1;
          end
          default: begin
            // Response while idle is dropped.
            n = 2'd0;
          end
        endcase
      end
    endcase
  end

  // Mark the final result of this item.
  always_comb begin
    res0 = r0;
    res1 = r1;
    res0.last = (n == 2'd1);
    res1.last = (n == 2'd2);
    res_count = n;
  end

endmodule

// ===== rtl/pmis_result_queue.sv =====
// ----------------------------------------------------------------------------
// pmis_result_queue
// Four-entry shifting result queue; takes up to two results per cycle.
// ----------------------------------------------------------------------------
module pmis_result_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_count,
  input  pmis_pkg::out_item_t push0,
  input  pmis_pkg::out_item_t push1,
  input  logic                pop,
  output logic                head_valid,
  output pmis_pkg::out_item_t head,
  output logic                almost_full
);
  import pmis_pkg::*;

  localparam int DEPTH = 4;

  out_item_t  q_r [DEPTH];
  out_item_t  q_nxt [DEPTH];
  logic [2:0] count_r;
  logic [2:0] count_nxt;
  logic [2:0] base;

  assign head_valid = (count_r != 3'd0);
  assign head = q_r[0];
  // Room for two more results is required before an item is taken.
  assign almost_full = (count_r > 3'd2);
  assign base = count_r - {2'b00, pop};

  // Shift on pop, then write new results behind the remaining entries.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (pop && (i < DEPTH - 1)) begin
        q_nxt[i] = q_r[i + 1];
      end else begin
        q_nxt[i] = q_r[i];
      end
    end
    if (push_count != 2'd0) begin
      q_nxt[base[1:0]] = push0;
    end
    if (push_count == 2'd2) begin
      q_nxt[base[1:0] + 2'd1] = push1;
    end
    count_nxt = base + {1'b0, push_count};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 3'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

// ===== rtl/phy_mdio_init_sequencer.sv =====
// ----------------------------------------------------------------------------
// phy_mdio_init_sequencer
// Drives PHY discovery, reset, advertisement and autonegotiation over a
// management bus, reporting link status or a timeout error.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid / in_stall  in_data (opcode, read_data)
//   out_      output     out_valid/ out_stall out_data (request, report, error)
//   cfg_      input      cfg_we               cfg_index, cfg_wdata
//
// An item is decoded in the cycle it is accepted; its zero, one or two results
// are registered into a four-entry result queue and reach out_ in arrival order.
// One item per cycle is accepted while the queue has room for two results.
// Reset is synchronous and clears the phase, held status and the queue.
// in_stall rises when out_stall holds the queue above two entries.
// ----------------------------------------------------------------------------
module phy_mdio_init_sequencer #(
  parameter logic [4:0] SCAN_START_ADDR = 5'd31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pmis_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pmis_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import pmis_pkg::*;

  cfg_t       cfg_r;
  seq_state_t st_r;
  seq_state_t st_nxt;
  out_item_t  res0;
  out_item_t  res1;
  logic [1:0] res_count;
  logic       in_accept;
  logic       out_pop;
  logic       q_full;

  assign in_accept = in_valid && !in_stall;
  assign out_pop = out_valid && !out_stall;
  assign in_stall = q_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_poll_limit <= RST_RESET_POLL_LIMIT;
      cfg_r.autoneg_poll_limit <= RST_AUTONEG_POLL_LIMIT;
      cfg_r.advertise_gig_bits <= RST_ADVERTISE_GIG;
      cfg_r.advertise_base_bits <= RST_ADVERTISE_BASE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RESET_POLL_LIMIT:   cfg_r.reset_poll_limit <= cfg_wdata;
        CFG_AUTONEG_POLL_LIMIT: cfg_r.autoneg_poll_limit <= cfg_wdata;
        CFG_ADVERTISE_GIG:      cfg_r.advertise_gig_bits <= cfg_wdata;
        default:                cfg_r.advertise_base_bits <= cfg_wdata;
      endcase
    end
  end

  pmis_step #(
    .SCAN_START_ADDR(SCAN_START_ADDR)
  ) u_step (
    .cur      (st_r),
    .cfg      (cfg_r),
    .item     (in_data),
    .nxt      (st_nxt),
    .res0     (res0),
    .res1     (res1),
    .res_count(res_count)
  );

  // Sequencer state advances only on an accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase <= PH_IDLE;
      st_r.found_address <= 5'd0;
      st_r.scan_address <= 5'd0;
      st_r.poll_left <= 16'd0;
      st_r.speed_held <= SPEED_10M;
      st_r.duplex_held <= 1'b0;
      st_r.link_held <= 1'b0;
    end else if (in_accept) begin
      st_r <= st_nxt;
    end
  end

  pmis_result_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_count (in_accept ? res_count : 2'd0),
    .push0      (res0),
    .push1      (res1),
    .pop        (out_pop),
    .head_valid (out_valid),
    .head       (out_data),
    .almost_full(q_full)
  );

endmodule

// ===== rtl/pmis_checker.sv =====
// ----------------------------------------------------------------------------
// pmis_checker
// Port-level checks on the sequencer's result stream.
// ----------------------------------------------------------------------------
module pmis_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input pmis_pkg::out_item_t out_data
);
  import pmis_pkg::*;

  // The result queue is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // A stalled result stays in place.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // An error ends the results of its item.
  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_ERROR |-> out_data.last &&
    (out_data.error_code == ERR_RESET_TO || out_data.error_code == ERR_AUTONEG_TO))
    else $error("error result malformed");

  // A write is always followed by the read that belongs to the same item.
  a_write_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_WRITE |-> !out_data.last)
    else $error("write marked as last result");

  // Only write requests carry data.
  a_wdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_WRITE |-> out_data.write_data == 16'd0)
    else $error("write data on a non-write result");

endmodule

bind phy_mdio_init_sequencer pmis_checker u_pmis_checker (.*);
